FILE: hdl/lru_pkg.sv
`timescale 1ns / 1ps

package lru_pkg;

    localparam int LRU_MAX_ENTRIES = 32;
    localparam int LRU_KEY_COUNT   = 26;
    localparam int KEY_W           = 5;
    localparam int CAP_W           = 6;
    localparam logic [CAP_W-1:0] CAP_RESET = 6'd1;

    localparam logic [1:0] ACT_ACCESS = 2'd0;
    localparam logic [1:0] ACT_PRINT  = 2'd1;
    localparam logic [1:0] ACT_CLEAR  = 2'd2;

    typedef struct packed {
        logic [1:0]       action;
        logic [KEY_W-1:0] key;
    } lru_in_t;

    typedef struct packed {
        logic [KEY_W-1:0] key_res;
        logic             last;
        logic             empty_res;
    } lru_out_t;

    // broadcast to every cell of the chain
    typedef struct packed {
        logic             shift;
        logic             hit_mode;
        logic             load;
        logic [KEY_W-1:0] load_data;
    } lru_cell_cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVICT,
        ST_PRINT
    } lru_state_t;

endpackage

FILE: hdl/lru_cell.sv
`timescale 1ns / 1ps

module lru_cell
    import lru_pkg::*;
(
    input  logic             aclk,
    input  lru_cell_cmd_t    cmd,
    input  logic             is_tail,
    input  logic             is_valid,
    input  logic             hit_in,
    output logic             hit_out,
    input  logic [KEY_W-1:0] next_entry,
    output logic [KEY_W-1:0] entry
);

    logic [KEY_W-1:0] entry_reg;
    logic [KEY_W-1:0] entry_next;
    logic             hit_here;

    assign hit_here = cmd.hit_mode && is_valid && (entry_reg == cmd.load_data);
    // once the hit is found, every cell above it pulls from its upper neighbor
    assign hit_out  = hit_in || hit_here;
    assign entry    = entry_reg;

    always_comb begin
        entry_next = entry_reg;
        if (cmd.load && is_tail) begin
            entry_next = cmd.load_data;
        end else if (cmd.shift || (cmd.hit_mode && hit_out)) begin
            entry_next = next_entry;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

endmodule

FILE: hdl/lru_replacement_order_core.sv
`timescale 1ns / 1ps

// LRU replacement order for letter keys, held in a chain of cells with the
// least recent entry in cell 0.
// Input channel s_valid/s_ready/s_data carries an action and a key; the
// result channel m_valid/m_ready/m_data carries print beats. Only a print
// produces beats: one per listed key, least recent first, last set on the
// final one, or a single beat with empty_res set when the list is empty.
// cfg_we/cfg_wdata write the capacity register (reset value 1); write it
// only while idle, the block itself does not enforce this. A miss after
// the capacity was lowered below the fill level first evicts the surplus
// entries, as the chain drops one head entry per cycle. A print gives one
// beat per listed key (fill level, at least 1); the list rotates through
// cell 0 and is back in order when the last beat is produced. s_ready is
// high only while no action is in progress.
// Results sit in an output register; a stalled receiver (m_ready low) holds
// the print, and a new action is taken while the final beat still waits.
// Reset (aresetn low, synchronous) empties the list and presence bits.
module lru_replacement_order_core
    import lru_pkg::*;
#(
    parameter int MAX_ENTRIES = LRU_MAX_ENTRIES,
    parameter int KEY_COUNT   = LRU_KEY_COUNT
)
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  lru_in_t          s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output lru_out_t         m_data,
    input  logic             cfg_we,
    input  logic [CAP_W-1:0] cfg_wdata
);

    localparam int FILL_W = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W  = (FILL_W > CAP_W) ? FILL_W + 1 : CAP_W + 1;

    lru_state_t           state_reg, state_next;
    logic [FILL_W-1:0]    fill_reg, fill_next;
    logic [KEY_COUNT-1:0] present_reg, present_next;
    logic [FILL_W-1:0]    cnt_reg, cnt_next;
    logic [KEY_W-1:0]     pend_key_reg, pend_key_next;
    logic [CAP_W-1:0]     cap_reg;
    lru_out_t             out_reg, out_next;
    logic                 m_valid_reg;

    lru_cell_cmd_t        cmd;
    logic [FILL_W-1:0]    tail_idx;
    logic [FILL_W-1:0]    cap_eff;
    logic [KEY_COUNT-1:0] key_oh;
    logic                 key_ok;
    logic                 hit;
    logic                 in_acc;
    logic                 out_free;
    logic                 emit;
    logic                 miss_go;
    logic [KEY_W-1:0]     miss_key;
    logic [KEY_W-1:0]     head;
    logic                 print_last;

    logic [KEY_W-1:0]     entries [MAX_ENTRIES];
    logic [MAX_ENTRIES:0] hit_chain;

    assign s_ready  = (state_reg == ST_IDLE);
    assign in_acc   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = out_reg;
    assign head     = entries[0];
    assign print_last = (cnt_reg == fill_reg - FILL_W'(1));

    always_comb begin
        if (cap_reg == '0) begin
            cap_eff = FILL_W'(1);
        end else if (CMP_W'(cap_reg) > CMP_W'(MAX_ENTRIES)) begin
            cap_eff = FILL_W'(MAX_ENTRIES);
        end else begin
            cap_eff = FILL_W'(cap_reg);
        end
    end

    always_comb begin
        for (int j = 0; j < KEY_COUNT; j++) begin
            key_oh[j] = (int'(s_data.key) == j);
        end
    end

    assign key_ok = (int'(s_data.key) < KEY_COUNT);
    assign hit    = |(present_reg & key_oh);

    // cell chain
    assign hit_chain[0] = 1'b0;

    for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
        logic [KEY_W-1:0] nxt;
        if (i == MAX_ENTRIES - 1) begin : g_top
            assign nxt = '0;
        end else begin : g_mid
            assign nxt = entries[i+1];
        end
        lru_cell u_cell (
            .aclk       (aclk),
            .cmd        (cmd),
            .is_tail    (tail_idx == FILL_W'(i)),
            .is_valid   (FILL_W'(i) < fill_reg),
            .hit_in     (hit_chain[i]),
            .hit_out    (hit_chain[i+1]),
            .next_entry (nxt),
            .entry      (entries[i])
        );
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    if (s_data.action == ACT_ACCESS && key_ok && !hit
                        && fill_reg > cap_eff) begin
                        state_next = ST_EVICT;
                    end else if (s_data.action == ACT_PRINT) begin
                        state_next = ST_PRINT;
                    end
                end
            end
            ST_EVICT: begin
                if (fill_reg <= cap_eff) begin
                    state_next = ST_IDLE;
                end
            end
            ST_PRINT: begin
                if (out_free && (fill_reg == '0 || print_last)) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // chain commands and bookkeeping
    always_comb begin
        cmd           = '0;
        tail_idx      = fill_reg - FILL_W'(1);
        fill_next     = fill_reg;
        present_next  = present_reg;
        cnt_next      = cnt_reg;
        pend_key_next = pend_key_reg;
        out_next      = out_reg;
        emit          = 1'b0;
        miss_go       = 1'b0;
        miss_key      = s_data.key;
        case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    case (s_data.action)
                        ACT_ACCESS: begin
                            if (key_ok && hit) begin
                                cmd.hit_mode  = 1'b1;
                                cmd.load      = 1'b1;
                                cmd.load_data = s_data.key;
                            end else if (key_ok) begin
                                miss_go = 1'b1;
                            end
                        end
                        ACT_PRINT: cnt_next = '0;
                        ACT_CLEAR: begin
                            fill_next    = '0;
                            present_next = '0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_EVICT: begin
                miss_go  = 1'b1;
                miss_key = pend_key_reg;
            end
            ST_PRINT: begin
                if (out_free) begin
                    emit = 1'b1;
                    if (fill_reg == '0) begin
                        out_next.key_res   = '0;
                        out_next.last      = 1'b1;
                        out_next.empty_res = 1'b1;
                    end else begin
                        out_next.key_res   = head;
                        out_next.last      = print_last;
                        out_next.empty_res = 1'b0;
                        // rotate the head round to the tail
                        cmd.shift     = 1'b1;
                        cmd.load      = 1'b1;
                        cmd.load_data = head;
                        cnt_next      = print_last ? '0 : cnt_reg + FILL_W'(1);
                    end
                end
            end
            default: ;
        endcase

        if (miss_go) begin
            cmd.load_data = miss_key;
            pend_key_next = miss_key;
            if (fill_reg >= cap_eff) begin
                cmd.shift = 1'b1;
                for (int j = 0; j < KEY_COUNT; j++) begin
                    if (int'(head) == j) begin
                        present_next[j] = 1'b0;
                    end
                end
                if (fill_reg == cap_eff) begin
                    cmd.load = 1'b1;
                    for (int j = 0; j < KEY_COUNT; j++) begin
                        if (int'(miss_key) == j) begin
                            present_next[j] = 1'b1;
                        end
                    end
                end else begin
                    fill_next = fill_reg - FILL_W'(1);
                end
            end else begin
                cmd.load  = 1'b1;
                tail_idx  = fill_reg;
                fill_next = fill_reg + FILL_W'(1);
                for (int j = 0; j < KEY_COUNT; j++) begin
                    if (int'(miss_key) == j) begin
                        present_next[j] = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            fill_reg    <= '0;
            present_reg <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
            cap_reg     <= CAP_RESET;
        end else begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            present_reg <= present_next;
            cnt_reg     <= cnt_next;
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_we) begin
                cap_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        out_reg      <= out_next;
        pend_key_reg <= pend_key_next;
    end

    // every listed key has exactly one presence bit
    assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(present_reg) == int'(fill_reg))
        else $error("presence bits out of step with fill level");

    assert property (@(posedge aclk) disable iff (!aresetn)
        int'(fill_reg) <= MAX_ENTRIES)
        else $error("fill level beyond chain length");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_acc && s_data.action == ACT_ACCESS && key_ok && hit) |=> $stable(fill_reg))
        else $error("hit changed the fill level");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_acc && s_data.action == ACT_CLEAR) |=> (fill_reg == '0 && present_reg == '0))
        else $error("clear left entries behind");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PRINT && fill_reg != '0) |-> (cnt_reg < fill_reg))
        else $error("print position past the list");

endmodule
